>>> rtl/cab_pkg.sv
package cab_pkg;

	localparam int unsigned TURNS      = 8;
	localparam int unsigned TURN_IDX_W = 3;
	localparam int unsigned STEP_W     = 14;
	localparam int unsigned ACC_W      = 16;
	localparam int unsigned IN_W       = 16;
	localparam int unsigned DIR_W      = 8;
	localparam int unsigned DP_W       = 24;
	localparam int unsigned NORM_BIT   = 20;

	localparam logic [TURN_IDX_W-1:0] TURN_LAST  = TURN_IDX_W'(TURNS - 1);
	localparam logic [ACC_W-1:0]      ROUND_HALF = ACC_W'(128);
	localparam logic [DIR_W-1:0]      QUARTER    = DIR_W'(64);
	localparam logic [DIR_W-1:0]      HALF_TURN  = DIR_W'(128);

	typedef logic [STEP_W-1:0] step_t;
	typedef step_t [TURNS-1:0] step_arr_t;

	// Rounded atan(2^-i) in 1/65536 of a circle.
	localparam step_arr_t STEP_RESET = '{
		step_t'(81), step_t'(163), step_t'(326), step_t'(651),
		step_t'(1297), step_t'(2555), step_t'(4836), step_t'(8192)
	};

	typedef struct packed {
		logic                  load;
		logic                  norm;
		logic                  turn;
		logic                  finish;
		logic [TURN_IDX_W-1:0] turn_idx;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic norm_done;
	} sts_t;

endpackage

>>> rtl/cab_cfg.sv
module cab_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [cab_pkg::TURN_IDX_W-1:0]   cfg_index,
	input  logic [cab_pkg::STEP_W-1:0]       cfg_data,
	output cab_pkg::step_arr_t               steps
);

	cab_pkg::step_arr_t steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= cab_pkg::STEP_RESET;
		end else if (cfg_wr_en) begin
			steps_q[cfg_index] <= cfg_data;
		end
	end

	assign steps = steps_q;

endmodule

>>> rtl/cab_dp.sv
module cab_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cab_pkg::cmd_t                 cmd,
	output cab_pkg::sts_t                 sts,
	input  logic [cab_pkg::IN_W-1:0]      delta_y,
	input  logic [cab_pkg::IN_W-1:0]      delta_x,
	input  cab_pkg::step_arr_t            steps,
	output logic [cab_pkg::DIR_W-1:0]     direction
);

	localparam int unsigned FW = cab_pkg::IN_W + 1;

	logic signed [cab_pkg::DP_W-1:0]  x_q, y_q;
	logic [cab_pkg::ACC_W-1:0]        acc_q;
	logic                             mirror_q, swap_q, base_q, zero_q;
	logic [cab_pkg::DIR_W-1:0]        dir_q;

	// Fold into the first octant.
	logic signed [FW-1:0]             fx0, fy0, fx1, fy1, fy2, fx3, fy3;
	logic                             f_base, f_mirror, f_swap, f_zero;

	always_comb begin
		fx0      = FW'(signed'(delta_x));
		fy0      = FW'(signed'(delta_y));
		f_zero   = (delta_x == '0) && (delta_y == '0);
		f_base   = fx0[FW-1];
		fx1      = f_base ? -fx0 : fx0;
		fy1      = f_base ? -fy0 : fy0;
		f_mirror = fy1[FW-1];
		fy2      = f_mirror ? -fy1 : fy1;
		f_swap   = fy2 > fx1;
		fx3      = f_swap ? fy2 : fx1;
		fy3      = f_swap ? fx1 : fy2;
	end

	// Normalize in coarse steps that never carry x past the limit.
	logic [4:0] norm_sh;

	always_comb begin
		if (x_q < (cab_pkg::DP_W'(1) << (cab_pkg::NORM_BIT - 8))) begin
			norm_sh = 5'd8;
		end else if (x_q < (cab_pkg::DP_W'(1) << (cab_pkg::NORM_BIT - 4))) begin
			norm_sh = 5'd4;
		end else if (x_q < (cab_pkg::DP_W'(1) << (cab_pkg::NORM_BIT - 2))) begin
			norm_sh = 5'd2;
		end else begin
			norm_sh = 5'd1;
		end
	end

	// One vectoring turn.
	logic signed [cab_pkg::DP_W-1:0] xs, ys;
	logic                            y_pos;
	logic [cab_pkg::ACC_W-1:0]       step_ext;

	always_comb begin
		xs       = x_q >>> cmd.turn_idx;
		ys       = y_q >>> cmd.turn_idx;
		y_pos    = !y_q[cab_pkg::DP_W-1] && (y_q != '0);
		step_ext = cab_pkg::ACC_W'(steps[cmd.turn_idx]);
	end

	// Round to whole steps and undo the fold.
	logic [cab_pkg::ACC_W-1:0] rnd;
	logic [cab_pkg::DIR_W-1:0] a0, a1, a2, a3;

	always_comb begin
		rnd = acc_q + cab_pkg::ROUND_HALF;
		a0  = rnd[cab_pkg::ACC_W-1 -: cab_pkg::DIR_W];
		a1  = swap_q ? cab_pkg::QUARTER - a0 : a0;
		a2  = mirror_q ? -a1 : a1;
		a3  = base_q ? a2 + cab_pkg::HALF_TURN : a2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			acc_q    <= '0;
			base_q   <= 1'b0;
			mirror_q <= 1'b0;
			swap_q   <= 1'b0;
			zero_q   <= 1'b0;
			dir_q    <= '0;
		end else begin
			if (cmd.load) begin
				x_q      <= cab_pkg::DP_W'(fx3);
				y_q      <= cab_pkg::DP_W'(fy3);
				acc_q    <= '0;
				base_q   <= f_base;
				mirror_q <= f_mirror;
				swap_q   <= f_swap;
				zero_q   <= f_zero;
			end else if (cmd.norm) begin
				x_q <= x_q <<< norm_sh;
				y_q <= y_q <<< norm_sh;
			end else if (cmd.turn) begin
				if (y_pos) begin
					x_q   <= x_q + ys;
					y_q   <= y_q - xs;
					acc_q <= acc_q + step_ext;
				end else begin
					x_q   <= x_q - ys;
					y_q   <= y_q + xs;
					acc_q <= acc_q - step_ext;
				end
			end
			if (cmd.finish) begin
				dir_q <= a3;
			end
		end
	end

	assign sts.zero      = zero_q;
	assign sts.norm_done = (x_q >= (cab_pkg::DP_W'(1) << cab_pkg::NORM_BIT));
	assign direction     = dir_q;

endmodule

>>> rtl/cab_ctrl.sv
module cab_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output cab_pkg::cmd_t cmd,
	input  cab_pkg::sts_t sts
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NORM = 2'd1;
	localparam logic [1:0] ST_TURN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]                     state_q, state_d;
	logic [cab_pkg::TURN_IDX_W-1:0] turn_cnt_q;
	logic                           done_q;
	logic                           accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (sts.zero) state_d = ST_FIN;
				else if (sts.norm_done) state_d = ST_TURN;
			end
			ST_TURN: begin
				if (turn_cnt_q == cab_pkg::TURN_LAST) state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			turn_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN);
			if (state_q == ST_TURN) begin
				turn_cnt_q <= turn_cnt_q + 1'b1;
			end else begin
				turn_cnt_q <= '0;
			end
		end
	end

	always_comb begin
		cmd.load     = accept;
		cmd.norm     = (state_q == ST_NORM) && !sts.zero && !sts.norm_done;
		cmd.turn     = (state_q == ST_TURN);
		cmd.finish   = (state_q == ST_FIN);
		cmd.turn_idx = turn_cnt_q;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

`ifndef SYNTHESIS
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("result strobe without a finishing cycle");
	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not start work");
	a_turns_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TURN && turn_cnt_q != cab_pkg::TURN_LAST) |=> (state_q == ST_TURN))
		else $error("turn sequence cut short");
	a_last_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TURN && turn_cnt_q == cab_pkg::TURN_LAST) |=> (state_q == ST_FIN))
		else $error("turn sequence overran");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");
`endif

endmodule

>>> rtl/cordic_atan2_byte_angle.sv
// Channel   Handshake            Payload
// command   start / busy         delta_y[15:0], delta_x[15:0]
// result    done (one cycle)     direction[7:0]
// config    cfg_wr_en            cfg_index[2:0], cfg_data[13:0]
//
// A transfer is taken when start is high and busy is low; done follows after
// two to five normalize shifts (set by the magnitude of the larger component),
// a check that sees the limit reached, the turns of the shared shift-add turn
// unit (one per angle step), and a finish state that rounds and unfolds; done
// is registered from the finish state. A zero vector goes from normalize
// straight to the finish state. The angle steps reset to atan(2^-i) and take
// writes at any time; the result strobe cannot be held off by the receiver.
module cordic_atan2_byte_angle (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [cab_pkg::IN_W-1:0]       delta_y,
	input  logic [cab_pkg::IN_W-1:0]       delta_x,
	output logic                           done,
	output logic [cab_pkg::DIR_W-1:0]      direction,
	input  logic                           cfg_wr_en,
	input  logic [cab_pkg::TURN_IDX_W-1:0] cfg_index,
	input  logic [cab_pkg::STEP_W-1:0]     cfg_data
);

	cab_pkg::cmd_t      cmd;
	cab_pkg::sts_t      sts;
	cab_pkg::step_arr_t steps;

	cab_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.steps     (steps)
	);

	cab_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	cab_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.delta_y   (delta_y),
		.delta_x   (delta_x),
		.steps     (steps),
		.direction (direction)
	);

endmodule
